FILE: rtl/itoa_pkg.sv
package itoa_pkg;

  localparam int unsigned ValueBitsDef = 64;
  localparam int unsigned MaxDigitsDef = 64;
  localparam int unsigned StepBits     = 4;

  localparam logic [7:0] CharZero     = 8'h30;
  localparam logic [7:0] CharMinus    = 8'h2d;
  localparam logic [7:0] CharUpperA   = 8'h41;
  localparam logic [7:0] CharLowerA   = 8'h61;
  localparam logic [4:0] SignedRadix  = 5'd10;
  localparam logic [4:0] RadixMin     = 5'd2;
  localparam logic [4:0] RadixMax     = 5'd16;

  typedef struct packed {
    logic        kind;
    logic [63:0] number;
    logic [4:0]  radix;
    logic        upper_case;
  } itoa_req_t;

  typedef struct packed {
    logic [7:0] ascii_char;
    logic       last_char;
  } itoa_res_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic up);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CharZero + {4'd0, d};
    end else if (up) begin
      c = CharUpperA + {4'd0, d - 4'd10};
    end else begin
      c = CharLowerA + {4'd0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

FILE: rtl/integer_to_ascii_radix_core.sv
// Conversion: the digits of a value come from one shared compare-subtract divider (4 quotient
// bits per cycle), then the digits are sent one character per cycle.
// A negative decimal value shows '-' in the cycle after start; a bad radix gives no output.
// No new start is taken until the last character is out; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops all output.
module integer_to_ascii_radix_core
  import itoa_pkg::*;
#(
  parameter int unsigned VALUE_BITS = ValueBitsDef,
  parameter int unsigned MAX_DIGITS = MaxDigitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  itoa_req_t req_i,
  output logic      res_valid_o,
  output itoa_res_t res_o
);

  localparam int unsigned DivGroups = (VALUE_BITS + StepBits - 1) / StepBits;
  localparam int unsigned DW = DivGroups * StepBits;
  localparam int unsigned GW = $clog2(DivGroups);
  localparam int unsigned AW = $clog2(MAX_DIGITS);
  localparam int unsigned CW = $clog2(MAX_DIGITS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [DW-1:0] a_q, a_d;
  logic [3:0]    r_q, r_d;
  logic [4:0]    base_q, base_d;
  logic          up_q, up_d;
  logic [GW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] n_q, n_d;
  logic [AW-1:0] p_q, p_d;
  logic          minus_q, minus_d;
  logic          pend_q, pend_d;
  logic          pend_last_q, pend_last_d;
  logic [3:0]    rd_q;
  logic [3:0]    mem [MAX_DIGITS];

  logic [VALUE_BITS-1:0] val;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;
  logic                  bad_radix;
  logic                  accept;
  logic [DW-1:0]         a_nx;
  logic [3:0]            r_nx;
  logic                  digit_done;
  logic                  wr_en;
  logic                  rd_en;

  assign val       = req_i.number[VALUE_BITS-1:0];
  assign neg       = req_i.kind & val[VALUE_BITS-1];
  assign mag       = neg ? (~val + 1'b1) : val;
  assign bad_radix = !req_i.kind && ((req_i.radix < RadixMin) || (req_i.radix > RadixMax));
  assign busy      = (state_q != ST_IDLE) || pend_q;
  assign accept    = start && !busy;

  always_comb begin
    logic [DW-1:0] a;
    logic [3:0]    r;
    logic [4:0]    t;
    logic [4:0]    diff;
    a = a_q;
    r = r_q;
    for (int i = 0; i < StepBits; i++) begin
      t    = {r, a[DW-1]};
      diff = t - base_q;
      a    = {a[DW-2:0], 1'b0};
      if (t >= base_q) begin
        r    = diff[3:0];
        a[0] = 1'b1;
      end else begin
        r = t[3:0];
      end
    end
    a_nx = a;
    r_nx = r;
  end

  assign digit_done = (state_q == ST_DIV) && (cnt_q == GW'(DivGroups - 1));
  assign wr_en      = digit_done;
  assign rd_en      = (state_q == ST_EMIT);

  always_comb begin
    state_d     = state_q;
    a_d         = a_q;
    r_d         = r_q;
    base_d      = base_q;
    up_d        = up_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    p_d         = p_q;
    minus_d     = 1'b0;
    pend_d      = 1'b0;
    pend_last_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !bad_radix) begin
          state_d = ST_DIV;
          a_d     = DW'(mag);
          r_d     = '0;
          base_d  = req_i.kind ? SignedRadix : req_i.radix;
          up_d    = req_i.upper_case & !req_i.kind;
          cnt_d   = '0;
          n_d     = '0;
          minus_d = neg;
        end
      end
      ST_DIV: begin
        a_d   = a_nx;
        r_d   = r_nx;
        cnt_d = cnt_q + 1'b1;
        if (digit_done) begin
          cnt_d = '0;
          r_d   = '0;
          n_d   = n_q + 1'b1;
          if ((a_nx == '0) || (n_d == CW'(MAX_DIGITS))) begin
            state_d = ST_EMIT;
            p_d     = n_q[AW-1:0];
          end
        end
      end
      ST_EMIT: begin
        pend_d      = 1'b1;
        pend_last_d = (p_q == '0);
        p_d         = p_q - 1'b1;
        if (p_q == '0) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      n_q         <= '0;
      p_q         <= '0;
      minus_q     <= 1'b0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      p_q         <= p_d;
      minus_q     <= minus_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    r_q    <= r_d;
    base_q <= base_d;
    up_q   <= up_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[n_q[AW-1:0]] <= r_nx;
    end
    if (rd_en) begin
      rd_q <= mem[p_q];
    end
  end

  assign res_valid_o      = minus_q | pend_q;
  assign res_o.ascii_char = minus_q ? CharMinus : digit_char(rd_q, up_q);
  assign res_o.last_char  = pend_q & pend_last_q;

  a_last_then_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last_char |=> !res_valid_o)
    else $error("output after final character");

  a_bad_radix_no_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && bad_radix |=> !busy && !res_valid_o)
    else $error("bad radix started a conversion");

  a_no_emit_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> !pend_q)
    else $error("digit output during division");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CW'(MAX_DIGITS))
    else $error("digit count overflow");

  a_minus_only_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    minus_q |-> $past(accept) && state_q == ST_DIV)
    else $error("minus sign outside start");

endmodule

FILE: tb/tb_integer_to_ascii_radix_core.sv
module tb_integer_to_ascii_radix_core;
  timeunit 1ns;
  timeprecision 1ps;

  import itoa_pkg::*;

  localparam logic KindUnsigned = 1'b0;
  localparam logic KindSigned   = 1'b1;
  localparam int   RandomItems  = 100;
  localparam int   QuietLimit   = 20000;
  localparam int   TailCycles   = 1100;

  typedef struct {
    itoa_req_t req;
    bit        drain_first;
  } pending_req_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      start       = 1'b0;
  itoa_req_t req_i       = '0;
  logic      busy;
  logic      res_valid_o;
  itoa_res_t res_o;

  pending_req_t pending_reqs[$];
  itoa_res_t    expected_chars[$];

  logic         req_taken    = 1'b0;
  int unsigned  gap_left     = 0;
  bit           burst_mode   = 1'b0;
  pending_req_t next_req;

  int unsigned  quiet_cycles  = 0;
  int unsigned  mismatches    = 0;
  int unsigned  chars_checked = 0;
  int unsigned  conversions   = 0;
  int unsigned  signed_cnt    = 0;
  int unsigned  rejected_cnt  = 0;
  logic [16:0]  radix_seen    = '0;

  integer_to_ascii_radix_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic radix_ok(input logic [4:0] radix);
    return radix >= RadixMin && radix <= RadixMax;
  endfunction

  // Expected character stream for one conversion.
  function automatic void predict_chars(input itoa_req_t r);
    logic [63:0] mag;
    logic [63:0] base;
    logic [3:0]  d;
    logic        up;
    logic [7:0]  digits[$];
    itoa_res_t   c;
    mag  = r.number;
    base = {59'd0, r.radix};
    up   = r.upper_case;
    if (r.kind == KindSigned) begin
      base = {59'd0, SignedRadix};
      up   = 1'b0;
      if (mag[63]) begin
        c.ascii_char = CharMinus;
        c.last_char  = 1'b0;
        expected_chars.push_back(c);
        mag = ~mag + 64'd1;
      end
    end else if (!radix_ok(r.radix)) begin
      return;
    end
    if (mag == 64'd0) begin
      digits.push_front(CharZero);
    end
    while (mag != 64'd0) begin
      d = 4'(mag % base);
      if (d < 4'd10) begin
        digits.push_front(CharZero + 8'(d));
      end else begin
        digits.push_front((up ? CharUpperA : CharLowerA) + 8'(d) - 8'd10);
      end
      mag = mag / base;
    end
    foreach (digits[i]) begin
      c.ascii_char = digits[i];
      c.last_char  = (i == digits.size() - 1);
      expected_chars.push_back(c);
    end
  endfunction

  function automatic void add_item(input logic kind, input logic [63:0] number,
                                   input logic [4:0] radix, input logic upper,
                                   input bit drain_first);
    pending_req_t p;
    p.req.kind       = kind;
    p.req.number     = number;
    p.req.radix      = radix;
    p.req.upper_case = upper;
    p.drain_first    = drain_first;
    pending_reqs.push_back(p);
  endfunction

  // Driver: a transfer completes at the rising edge where start is high and busy low.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start    <= 1'b0;
      req_i    <= '0;
      gap_left = 0;
    end else if (!start || req_taken) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        start <= 1'b0;
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].drain_first &&
                     (expected_chars.size() != 0 || busy))) begin
        next_req = pending_reqs.pop_front();
        req_i    <= next_req.req;
        start    <= 1'b1;
        gap_left = burst_mode ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 15) == 0) begin
          burst_mode = !burst_mode;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor, checker and watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected char %02h last=%0b, nothing pending",
                     $realtime, res_o.ascii_char, res_o.last_char);
          end
        end else begin
          if (res_o.ascii_char !== expected_chars[0].ascii_char ||
              res_o.last_char !== expected_chars[0].last_char) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: char mismatch: expected %02h last=%0b, got %02h last=%0b",
                       $realtime, expected_chars[0].ascii_char,
                       expected_chars[0].last_char, res_o.ascii_char, res_o.last_char);
            end
          end
          void'(expected_chars.pop_front());
        end
      end
      if (start && !busy) begin
        predict_chars(req_i);
        conversions++;
        if (req_i.kind == KindSigned) begin
          signed_cnt++;
        end else if (!radix_ok(req_i.radix)) begin
          rejected_cnt++;
        end else begin
          radix_seen[req_i.radix] = 1'b1;
        end
      end
      req_taken <= start && !busy;
      if (res_valid_o || (start && !busy)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("timeout: no transfer for %0d cycles", QuietLimit);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned valid_cnt;
    logic        kind;
    logic [63:0] number;
    logic [4:0]  radix;
    logic        upper;

    // directed
    add_item(KindUnsigned, 64'd0, 5'd10, 1'b0, 1'b0);
    add_item(KindSigned, 64'd0, 5'd10, 1'b0, 1'b0);
    add_item(KindUnsigned, '1, 5'd2, 1'b0, 1'b0);
    add_item(KindUnsigned, '1, 5'd16, 1'b1, 1'b0);
    add_item(KindUnsigned, 64'hfedc_ba98_7654_3210, 5'd16, 1'b0, 1'b0);
    add_item(KindUnsigned, 64'hfedc_ba98_7654_3210, 5'd16, 1'b1, 1'b0);
    add_item(KindUnsigned, '1, 5'd8, 1'b0, 1'b0);
    add_item(KindUnsigned, '1, 5'd3, 1'b0, 1'b0);
    add_item(KindUnsigned, '1, 5'd10, 1'b1, 1'b0);
    add_item(KindSigned, 64'h8000_0000_0000_0000, 5'd0, 1'b1, 1'b0);
    add_item(KindSigned, '1, 5'd31, 1'b0, 1'b0);
    add_item(KindSigned, 64'h7fff_ffff_ffff_ffff, 5'd16, 1'b1, 1'b0);
    add_item(KindSigned, 64'd12345, 5'd2, 1'b0, 1'b0);
    add_item(KindUnsigned, 64'd5, 5'd0, 1'b0, 1'b0);
    add_item(KindUnsigned, 64'd5, 5'd1, 1'b1, 1'b0);
    add_item(KindUnsigned, 64'd5, 5'd17, 1'b0, 1'b0);
    add_item(KindUnsigned, '1, 5'd31, 1'b1, 1'b0);
    add_item(KindUnsigned, 64'd15, 5'd16, 1'b0, 1'b1);
    add_item(KindUnsigned, 64'd1, 5'd2, 1'b0, 1'b0);
    add_item(KindUnsigned, 64'd120, 5'd11, 1'b1, 1'b0);
    add_item(KindUnsigned, 64'h0123_4567_89ab_cdef, 5'd7, 1'b0, 1'b0);
    add_item(KindSigned, 64'hffff_ffff_ffff_fff6, 5'd10, 1'b0, 1'b0);
    add_item(KindUnsigned, 64'd9, 5'd10, 1'b0, 1'b0);

    // random
    valid_cnt = 0;
    while (valid_cnt < RandomItems) begin
      case ($urandom_range(0, 5))
        0:       number = {$urandom, $urandom};
        1:       number = 64'($urandom_range(0, 40));
        2:       number = {$urandom, $urandom} >> $urandom_range(0, 63);
        3:       number = 64'd1 << $urandom_range(0, 63);
        4:       number = ~(64'd1 << $urandom_range(0, 63)) + 64'($urandom_range(0, 2));
        default: number = {$urandom, $urandom} >> $urandom_range(40, 60);
      endcase
      upper = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 30) begin
        kind  = KindSigned;
        radix = 5'($urandom_range(0, 31));
      end else begin
        kind = KindUnsigned;
        if ($urandom_range(0, 9) == 0) begin
          radix = $urandom_range(0, 1) ? 5'($urandom_range(0, 1)) : 5'($urandom_range(17, 31));
        end else begin
          radix = 5'($urandom_range(2, 16));
        end
      end
      add_item(kind, number, radix, upper, $urandom_range(0, 39) == 0);
      if (kind == KindSigned || radix_ok(radix)) begin
        valid_cnt++;
      end
    end

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    do begin
      @(negedge clk_i);
    end while (pending_reqs.size() != 0 || start || expected_chars.size() != 0);
    repeat (TailCycles) @(posedge clk_i);

    if (expected_chars.size() != 0) begin
      $display("%0d expected characters never arrived", expected_chars.size());
    end
    $display("converted %0d numbers (%0d signed, %0d with rejected radix), %0d chars checked",
             conversions, signed_cnt, rejected_cnt, chars_checked);
    $display("unsigned radices exercised: %0d of 15, mismatches: %0d",
             $countones(radix_seen), mismatches);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
